/* sv/mtdm_pkg.sv */
// Shared types and constants for the multi-tap delay mixer.
// No dependencies; every other file of the block but mtdm_ram refers to it by scoped names.

package mtdm_pkg;

	// Field widths
	localparam int SAMPLE_W   = 16;
	localparam int DELAY_W    = 10;
	localparam int GAIN_W     = 16;
	localparam int MIX_W      = 19;
	localparam int TAP_SLOTS  = 4;
	localparam int TAP_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Product magnitude and per-tap term widths
	localparam int PROD_W = 2 * SAMPLE_W;
	localparam int Q15    = 15;
	localparam int QUOT_W = PROD_W - Q15;
	localparam int TERM_W = QUOT_W + 1;

	// Q15 gain divisor (0x7fff) and twice it
	localparam logic [QUOT_W-1:0] GAIN_DIV   = QUOT_W'(32'h0000_7fff);
	localparam logic [QUOT_W-1:0] GAIN_DIV_2 = QUOT_W'(32'h0000_fffe);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TAP0_DELAY = 3'd0,
		REG_TAP1_DELAY = 3'd1,
		REG_TAP2_DELAY = 3'd2,
		REG_TAP3_DELAY = 3'd3,
		REG_TAP0_GAIN  = 3'd4,
		REG_TAP1_GAIN  = 3'd5,
		REG_TAP2_GAIN  = 3'd6,
		REG_TAP3_GAIN  = 3'd7
	} cfg_reg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic             accept;
		logic             issue;
		logic [TAP_W-1:0] tap;
		logic             load_out;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic cfg_busy;
		logic pipe_busy;
	} dp_sts_t;

endpackage

/* sv/mtdm_if.sv */
// Handshake channels of the multi-tap delay mixer: audio in, mix out, register writes.
// Depends on mtdm_pkg for payload widths.

interface mtdm_audio_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [mtdm_pkg::SAMPLE_W-1:0]  sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface mtdm_mix_if;
	logic                               valid;
	logic                               ready;
	logic signed [mtdm_pkg::MIX_W-1:0]  mixed_out;

	modport source (output valid, output mixed_out, input ready);
	modport sink   (input valid, input mixed_out, output ready);
endinterface

interface mtdm_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [mtdm_pkg::CFG_IDX_W-1:0]    index;
	logic [mtdm_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/mtdm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module mtdm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/mtdm_ctrl.sv */
// Sequencer of the multi-tap delay mixer: input/output handshake and tap stepping.
// Depends on mtdm_pkg for the command and status structs.

module mtdm_ctrl #(
	parameter int NUM_TAPS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  mtdm_pkg::dp_sts_t   sts,
	output mtdm_pkg::dp_cmd_t   cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	localparam logic [mtdm_pkg::TAP_W-1:0] LAST_TAP = mtdm_pkg::TAP_W'(NUM_TAPS - 1);

	state_t                      state_q, state_d;
	logic [mtdm_pkg::TAP_W-1:0]  tap_q;
	logic                        out_valid_q;
	logic                        slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Commands
	always_comb begin
		in_ready     = (state_q == ST_IDLE) && !sts.cfg_busy;
		cmd.accept   = in_ready && in_valid;
		cmd.issue    = (state_q == ST_RUN);
		cmd.tap      = tap_q;
		cmd.load_out = (state_q == ST_DRAIN) && !sts.pipe_busy && slot_free;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.accept) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (tap_q == LAST_TAP) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (cmd.load_out) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State, tap counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tap_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				tap_q <= '0;
			end else if (cmd.issue) begin
				tap_q <= tap_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/mtdm_dp.sv */
// Datapath of the multi-tap delay mixer: config registers, delay store, tap pipeline.
// Depends on mtdm_pkg and mtdm_ram.

module mtdm_dp #(
	parameter int STORE_DEPTH = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mtdm_pkg::dp_cmd_t                    cmd,
	output mtdm_pkg::dp_sts_t                    sts,
	input  logic signed [mtdm_pkg::SAMPLE_W-1:0] sample_in,
	input  logic                                 cfg_we,
	input  logic [mtdm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mtdm_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic signed [mtdm_pkg::MIX_W-1:0]    mixed_out
);

	localparam int AW  = $clog2(STORE_DEPTH);
	localparam int AW1 = AW + 1;
	localparam int DW  = mtdm_pkg::DELAY_W;
	localparam int SW  = mtdm_pkg::SAMPLE_W;
	localparam int GW  = mtdm_pkg::GAIN_W;
	localparam int TW  = mtdm_pkg::TAP_W;
	localparam int PW  = mtdm_pkg::PROD_W;
	localparam int QW  = mtdm_pkg::QUOT_W;
	localparam int RW  = mtdm_pkg::TERM_W;
	localparam int MW  = mtdm_pkg::MIX_W;
	localparam logic [AW1-1:0] DEPTH_W  = AW1'(STORE_DEPTH);
	localparam logic [AW-1:0]  WP_RESET = AW'(STORE_DEPTH - 1);

	// ---------------- configuration registers ----------------
	logic [AW-1:0]   delay_q [mtdm_pkg::TAP_SLOTS];
	logic [GW-1:0]   gain_q  [mtdm_pkg::TAP_SLOTS];
	logic            delay_sel;
	logic [TW-1:0]   cfg_tap;

	// Delay writes are reduced modulo the depth over two stages
	logic            red_v_s1, red_v_s2;
	logic [DW-1:0]   red_val_s1, red_val_s2;
	logic [TW-1:0]   red_tap_s1, red_tap_s2;
	logic [AW-1:0]   red_mod;

	assign cfg_tap = cfg_index[TW-1:0];

	// Register decode
	always_comb begin
		unique case (cfg_index) inside
			mtdm_pkg::REG_TAP0_DELAY, mtdm_pkg::REG_TAP1_DELAY,
			mtdm_pkg::REG_TAP2_DELAY, mtdm_pkg::REG_TAP3_DELAY: delay_sel = 1'b1;
			default: delay_sel = 1'b0;
		endcase
	end

	// Reduction stage payload
	always_ff @(posedge clk) begin
		red_val_s1 <= cfg_data[DW-1:0];
		red_tap_s1 <= cfg_tap;
		red_val_s2 <= red_val_s1;
		red_tap_s2 <= red_tap_s1;
	end

	generate
		if (STORE_DEPTH < (1 << DW)) begin : g_mod
			// Reciprocal is exact for every delay value below 2**DW
			localparam int RS = 2 * DW;
			localparam int PQ = DW + RS;
			localparam logic [RS-1:0] RECIP = RS'(((1 << RS) + STORE_DEPTH - 1) / STORE_DEPTH);
			localparam logic [DW-1:0] DEP_D = DW'(STORE_DEPTH);
			logic [PQ-1:0]   qprod;
			logic [DW-1:0]   red_q_s2;
			logic [2*DW-1:0] qd;
			logic [DW-1:0]   rem;

			assign qprod = PQ'(red_val_s1) * PQ'(RECIP);
			always_ff @(posedge clk) begin
				red_q_s2 <= qprod[PQ-1:RS];
			end
			assign qd      = (2*DW)'(red_q_s2) * (2*DW)'(DEP_D);
			assign rem     = red_val_s2 - qd[DW-1:0];
			assign red_mod = AW'(rem);
		end else begin : g_nomod
			assign red_mod = AW'(red_val_s2);
		end
	endgenerate

	// Register file and reduction valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_v_s1 <= 1'b0;
			red_v_s2 <= 1'b0;
			for (int i = 0; i < mtdm_pkg::TAP_SLOTS; i++) begin
				delay_q[i] <= '0;
				gain_q[i]  <= '0;
			end
		end else begin
			red_v_s1 <= cfg_we && delay_sel;
			red_v_s2 <= red_v_s1;
			if (cfg_we && !delay_sel) begin
				gain_q[cfg_tap] <= cfg_data[GW-1:0];
			end
			if (red_v_s2) begin
				delay_q[red_tap_s2] <= red_mod;
			end
		end
	end

	// ---------------- write pointer and fill state ----------------
	logic [AW-1:0] wp_q;
	logic          full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= WP_RESET;
			full_q <= 1'b0;
		end else if (cmd.accept) begin
			wp_q <= (wp_q == '0) ? WP_RESET : wp_q - 1'b1;
			if (wp_q == '0) full_q <= 1'b1;
		end
	end

	// ---------------- tap read issue ----------------
	logic [AW1-1:0] idx_sum;
	logic [AW-1:0]  rd_idx;
	logic           rd_live;
	logic [SW-1:0]  rdata;

	assign idx_sum = {1'b0, wp_q} + {1'b0, delay_q[cmd.tap]};
	assign rd_idx  = (idx_sum >= DEPTH_W) ? AW'(idx_sum - DEPTH_W) : idx_sum[AW-1:0];
	// Entries above the pointer have been written since reset; the rest still read as zero
	assign rd_live = full_q || (rd_idx > wp_q);

	mtdm_ram #(
		.WIDTH (SW),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.accept),
		.waddr (wp_q),
		.wdata (sample_in),
		.re    (cmd.issue),
		.raddr (rd_idx),
		.rdata (rdata)
	);

	// ---------------- tap pipeline ----------------
	logic                  v_s1, v_s2, v_s3;
	logic                  live_s1;
	logic [TW-1:0]         tap_s1;
	logic [SW-1:0]         smp;
	logic [GW-1:0]         gain;
	logic [SW-1:0]         mag_s;
	logic [GW-1:0]         mag_g;
	logic [PW-1:0]         mag_s2;
	logic                  neg_s2;
	logic [QW-1:0]         hi, lo_x, fold, quot;
	logic [1:0]            corr;
	logic signed [RW-1:0]  quot_sg;
	logic signed [RW-1:0]  term_s3;
	logic signed [MW-1:0]  acc_q;
	logic signed [MW-1:0]  mix_q;

	// Stage 1: magnitudes of sample and gain, one multiply
	assign smp   = live_s1 ? rdata : '0;
	assign gain  = gain_q[tap_s1];
	assign mag_s = smp[SW-1] ? (~smp + 1'b1) : smp;
	assign mag_g = gain[GW-1] ? (~gain + 1'b1) : gain;

	// Stage 2: divide by 0x7fff as hi + (hi + lo) / 0x7fff, the latter at most two
	assign hi   = mag_s2[PW-1:mtdm_pkg::Q15];
	assign lo_x = QW'(mag_s2[mtdm_pkg::Q15-1:0]);
	assign fold = hi + lo_x;
	always_comb begin
		if (fold >= mtdm_pkg::GAIN_DIV_2) begin
			corr = 2'd2;
		end else if (fold >= mtdm_pkg::GAIN_DIV) begin
			corr = 2'd1;
		end else begin
			corr = 2'd0;
		end
	end
	assign quot    = hi + QW'(corr);
	assign quot_sg = signed'({1'b0, quot});

	always_ff @(posedge clk) begin
		live_s1 <= rd_live;
		tap_s1  <= cmd.tap;
		mag_s2  <= PW'(mag_s) * PW'(mag_g);
		neg_s2  <= smp[SW-1] ^ gain[GW-1];
		term_s3 <= neg_s2 ? -quot_sg : quot_sg;
		if (cmd.accept) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= acc_q + MW'(term_s3);
		end
		if (cmd.load_out) begin
			mix_q <= acc_q;
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign sts.pipe_busy = v_s1 || v_s2 || v_s3;
	assign sts.cfg_busy  = red_v_s1 || red_v_s2;
	assign mixed_out     = mix_q;

endmodule

/* sv/multi_tap_delay_mixer.sv */
// Top level of the multi-tap delay mixer: sequencer plus datapath on three channels.
// Depends on mtdm_pkg, mtdm_if, mtdm_ctrl and mtdm_dp.

// Each accepted audio sample is written into a circular store of STORE_DEPTH
// entries; then each of the NUM_TAPS taps reads the store at its delay from the
// write position, scales the sample by its signed Q15 gain (divided by 0x7fff,
// truncated toward zero) and the terms are summed into one mix beat. For each
// sample the taps go one per cycle through the store's single read port and
// one shared 16x16 multiplier, followed by a three-stage drain, the output load
// and the idle state in which the next sample is taken. A finished mix waits in
// an output register, so the next sample is taken while that beat is still
// unclaimed. The store needs no clearing pass: entries not yet written since
// reset read as zero. A write to a delay register holds off the audio input
// while the delay is reduced modulo the store depth; register writes are
// always taken.

module multi_tap_delay_mixer #(
	parameter int STORE_DEPTH = 1024,
	parameter int NUM_TAPS    = 4
) (
	input logic          clk,
	input logic          arst_n,
	mtdm_audio_if.sink   audio,
	mtdm_mix_if.source   mix,
	mtdm_cfg_if.sink     cfg
);

	mtdm_pkg::dp_cmd_t cmd;
	mtdm_pkg::dp_sts_t sts;
	logic              cfg_we;

	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;

	mtdm_ctrl #(
		.NUM_TAPS (NUM_TAPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (audio.valid),
		.in_ready  (audio.ready),
		.out_valid (mix.valid),
		.out_ready (mix.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mtdm_dp #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.sample_in (audio.sample_in),
		.cfg_we    (cfg_we),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.mixed_out (mix.mixed_out)
	);

endmodule

/* sv/mtdm_checker.sv */
// Port-level checks of the multi-tap delay mixer, bound to the top level.
// Depends on mtdm_pkg and multi_tap_delay_mixer.

module mtdm_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 audio_valid,
	input logic                                 audio_ready,
	input logic                                 mix_valid,
	input logic                                 mix_ready,
	input logic signed [mtdm_pkg::MIX_W-1:0]    mixed_out,
	input logic                                 cfg_valid,
	input logic                                 cfg_ready,
	input logic [mtdm_pkg::CFG_IDX_W-1:0]       cfg_index
);

	logic       in_beat, out_beat, delay_wr;
	logic [1:0] pending_q;

	assign in_beat  = audio_valid && audio_ready;
	assign out_beat = mix_valid && mix_ready;
	assign delay_wr = cfg_valid && cfg_ready && (cfg_index < mtdm_pkg::REG_TAP0_GAIN);

	// Samples taken but not yet delivered as mix beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {1'b0, in_beat} - {1'b0, out_beat};
		end
	end

	// A stalled mix beat holds its value
	a_mix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mix_valid && !mix_ready |=> mix_valid && $stable(mixed_out))
		else $error("mix beat dropped or changed while stalled");

	// No mix beat without a sample behind it
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> pending_q != 2'd0)
		else $error("mix beat without an outstanding sample");

	// At most one finished mix waits when a new sample is taken
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |-> pending_q < 2'd2)
		else $error("sample taken with too many mixes outstanding");

	// Input is held off while a delay write is being reduced
	a_delay_hold: assert property (@(posedge clk) disable iff (!arst_n)
		delay_wr |=> !audio_ready)
		else $error("audio taken during a delay register update");

endmodule

bind multi_tap_delay_mixer mtdm_checker u_mtdm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.audio_valid (audio.valid),
	.audio_ready (audio.ready),
	.mix_valid   (mix.valid),
	.mix_ready   (mix.ready),
	.mixed_out   (mix.mixed_out),
	.cfg_valid   (cfg.valid),
	.cfg_ready   (cfg.ready),
	.cfg_index   (cfg.index)
);
